[hw/rtl/chunked_first_fit_allocator_defines.svh]
// Assertion macros used by the checker file
`ifndef CHUNKED_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`define CHUNKED_FIRST_FIT_ALLOCATOR_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define CFFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication checked outside reset
`define CFFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

[hw/rtl/cffa_pkg.sv]
package cffa_pkg;
  localparam int unsigned NumChunksDef = 8;
  localparam int unsigned MaxPieces    = 8;
  localparam int unsigned SizeW        = 16;
  localparam int unsigned CountW       = 4;
  localparam int unsigned IndexW       = 3;
  localparam logic        ReqLoad      = 1'b0;
  localparam logic        ReqAlloc     = 1'b1;

  // One result item
  typedef struct packed {
    logic             placed;
    logic [SizeW-1:0] piece_size;
    logic [SizeW-1:0] piece_address;
    logic             last_piece;
  } result_t;

  // One table entry
  typedef struct packed {
    logic [SizeW-1:0] size;
    logic [SizeW-1:0] start;
  } entry_t;
endpackage

[hw/rtl/cffa_ram.sv]
// Generic single-port-write, one-read RAM with registered read data
module cffa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/cffa_out_buf.sv]
// Single-entry output register; slot frees as soon as the result is taken
module cffa_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cffa_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output cffa_pkg::result_t out_data
);
  logic              vld_r;
  cffa_pkg::result_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (push) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

  assign full      = vld_r && !out_ready;
  assign out_valid = vld_r;
  assign out_data  = data_r;
endmodule

[hw/rtl/chunked_first_fit_allocator.sv]
// Channel | Direction | Transfer contents
// in_*    | input     | load entry or allocation request
// out_*   | output    | one used piece, or one failure
// cfg_*   | input     | chunk_count register
// A load is written to the table when it is accepted. An allocation tries the
// single-fit scan over the entries, then the pair scan over each first chunk
// (states R2A, R2B, R2C), then the run scan, until one fits; it then reads and
// emits each piece (states URD, UWR), or emits one failure.
// Reset (synchronous, rst_n low) sets chunk_count to 1; the table is not cleared.
// A stalled output holds the sequencer at the piece that waits.
module chunked_first_fit_allocator #(
  parameter int unsigned NUM_CHUNKS = cffa_pkg::NumChunksDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [cffa_pkg::IndexW-1:0]   in_chunk_index,
  input  logic [cffa_pkg::SizeW-1:0]    in_chunk_size,
  input  logic [cffa_pkg::SizeW-1:0]    in_chunk_start,
  input  logic [cffa_pkg::SizeW-1:0]    in_request_size,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_placed,
  output logic [cffa_pkg::SizeW-1:0]    out_piece_size,
  output logic [cffa_pkg::SizeW-1:0]    out_piece_address,
  output logic                          out_last_piece,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cffa_pkg::CountW-1:0]   cfg_chunk_count
);
  localparam int unsigned AW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int unsigned RD = 1 << AW;
  localparam int unsigned LimN = (NUM_CHUNKS < cffa_pkg::MaxPieces) ?
                                 NUM_CHUNKS : cffa_pkg::MaxPieces;
  localparam int unsigned SW = cffa_pkg::SizeW;

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_R1    = 4'd1;  // single-fit scan
  localparam logic [3:0] S_R2A   = 4'd2;  // pair: read first
  localparam logic [3:0] S_R2B   = 4'd3;  // pair: read second
  localparam logic [3:0] S_R3    = 4'd4;  // run scan
  localparam logic [3:0] S_URD   = 4'd5;  // use: read entry
  localparam logic [3:0] S_UWR   = 4'd6;  // use: emit and write back
  localparam logic [3:0] S_FAIL  = 4'd7;
  localparam logic [3:0] S_R2C   = 4'd8;  // pair: compare

  // Rule that placed the request
  localparam logic [1:0] M_SINGLE = 2'd0;
  localparam logic [1:0] M_PAIR   = 2'd1;
  localparam logic [1:0] M_RUN    = 2'd2;

  logic [3:0]               st_r, st_nxt;
  logic [cffa_pkg::CountW-1:0] cnt_r;
  logic [3:0]               n;
  logic [SW-1:0]            need_r, need_nxt;
  logic [SW-1:0]            req_r, req_nxt;
  logic [3:0]               j_r, j_nxt, k_r, k_nxt;
  logic [3:0]               fin_r, fin_nxt;   // last chunk used
  logic [3:0]               ucur_r, ucur_nxt; // chunk being used
  logic [1:0]               mode_r, mode_nxt; // placing rule
  logic [SW:0]              acc_r, acc_nxt;
  logic [SW-1:0]            szj_r, szj_nxt;

  logic                     we;
  logic [AW-1:0]            waddr, raddr;
  cffa_pkg::entry_t         wdata, rdata;
  logic [3:0]               rsel;
  logic                     push, full;
  cffa_pkg::result_t        res;
  cffa_pkg::result_t        odata;
  logic [SW-1:0]            amt;

  // chunk_count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= cffa_pkg::CountW'(1);
    end else if (cfg_valid && cfg_ready) begin
      cnt_r <= cfg_chunk_count;
    end
  end
  assign cfg_ready = 1'b1;
  assign n = (cnt_r > 4'(LimN)) ? 4'(LimN) : cnt_r;

  cffa_ram #(.Width($bits(cffa_pkg::entry_t)), .Depth(RD)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );
  assign raddr = AW'(rsel);

  cffa_out_buf u_obuf (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(res), .full(full),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(odata)
  );
  assign out_placed        = odata.placed;
  assign out_piece_size    = odata.piece_size;
  assign out_piece_address = odata.piece_address;
  assign out_last_piece    = odata.last_piece;

  assign in_ready = (st_r == S_IDLE);
  assign amt = (need_r < rdata.size) ? need_r : rdata.size;

  // Sequencer
  always_comb begin
    st_nxt = st_r; need_nxt = need_r; req_nxt = req_r; j_nxt = j_r; k_nxt = k_r;
    fin_nxt = fin_r; ucur_nxt = ucur_r; mode_nxt = mode_r; acc_nxt = acc_r;
    szj_nxt = szj_r;
    rsel = j_r; we = 1'b0; waddr = '0; wdata = '0; push = 1'b0; res = '0;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == cffa_pkg::ReqLoad) begin
            if (32'(in_chunk_index) < NUM_CHUNKS) begin
              we = 1'b1;
              waddr = AW'(in_chunk_index);
              wdata.size = in_chunk_size;
              wdata.start = in_chunk_start;
            end
          end else begin
            req_nxt = in_request_size;
            j_nxt = '0;
            rsel = '0;
            st_nxt = (n == 4'd0) ? S_FAIL : S_R1;
          end
        end
      end
      S_R1: begin
        // rdata holds entry j_r
        if ({1'b0, rdata.size} >= {1'b0, req_r}) begin
          mode_nxt = M_SINGLE; ucur_nxt = j_r; fin_nxt = j_r; need_nxt = req_r;
          rsel = j_r; st_nxt = S_URD;
        end else if (j_r + 4'd1 < n) begin
          j_nxt = j_r + 4'd1; rsel = j_r + 4'd1;
        end else if (n > 4'd1) begin
          j_nxt = '0; k_nxt = 4'd1; rsel = '0; st_nxt = S_R2A;
        end else begin
          st_nxt = S_FAIL;
        end
      end
      S_R2A: begin
        // address j_r presented last cycle; capture size, read k
        szj_nxt = rdata.size; rsel = k_r; st_nxt = S_R2B;
      end
      S_R2B: begin
        st_nxt = S_R2C; rsel = k_r;
      end
      S_R2C: begin
        if (k_r != j_r && ({1'b0, szj_r} + {1'b0, rdata.size}) >= {1'b0, req_r}) begin
          mode_nxt = M_PAIR; ucur_nxt = j_r; fin_nxt = k_r; need_nxt = req_r;
          rsel = j_r; st_nxt = S_URD;
        end else if (k_r + 4'd1 < n) begin
          k_nxt = k_r + 4'd1; rsel = k_r + 4'd1; st_nxt = S_R2B;
        end else if (j_r + 4'd2 < n) begin
          j_nxt = j_r + 4'd1; k_nxt = 4'd1; rsel = j_r + 4'd1; st_nxt = S_R2A;
        end else if (n > 4'd2) begin
          j_nxt = '0; acc_nxt = '0; rsel = '0; st_nxt = S_R3;
        end else begin
          st_nxt = S_FAIL;
        end
      end
      S_R3: begin
        // 17-bit accumulation; each step compares before the next add
        if (acc_r + {1'b0, rdata.size} >= {1'b0, req_r}) begin
          mode_nxt = M_RUN; ucur_nxt = '0; fin_nxt = j_r; need_nxt = req_r;
          rsel = '0; st_nxt = S_URD;
        end else if (j_r + 4'd1 < n) begin
          acc_nxt = acc_r + {1'b0, rdata.size};
          j_nxt = j_r + 4'd1; rsel = j_r + 4'd1;
        end else begin
          st_nxt = S_FAIL;
        end
      end
      S_URD: begin
        rsel = ucur_r; st_nxt = S_UWR;
      end
      S_UWR: begin
        rsel = ucur_r;
        if (!full) begin
          push = 1'b1;
          res.placed = 1'b1;
          res.piece_size = rdata.size;
          res.piece_address = rdata.start;
          res.last_piece = (ucur_r == fin_r);
          we = 1'b1;
          waddr = AW'(ucur_r);
          wdata.size = rdata.size - amt;
          wdata.start = rdata.start + amt;
          need_nxt = need_r - amt;
          if (ucur_r == fin_r) begin
            st_nxt = S_IDLE;
          end else begin
            ucur_nxt = (mode_r == M_PAIR) ? fin_r : ucur_r + 4'd1;
            st_nxt = S_URD;
          end
        end
      end
      S_FAIL: begin
        if (!full) begin
          push = 1'b1;
          res.last_piece = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r <= need_nxt; req_r <= req_nxt; j_r <= j_nxt; k_r <= k_nxt;
    fin_r <= fin_nxt; ucur_r <= ucur_nxt; mode_r <= mode_nxt; acc_r <= acc_nxt;
    szj_r <= szj_nxt;
  end
endmodule

[hw/rtl/cffa_checker.sv]
`include "chunked_first_fit_allocator_defines.svh"
module cffa_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_req_type,
  input logic out_valid,
  input logic out_ready,
  input logic out_placed,
  input logic [15:0] out_piece_size,
  input logic [15:0] out_piece_address,
  input logic out_last_piece
);
  // Failure result carries zero payload and ends the request
  `CFFA_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && !out_placed, out_last_piece && out_piece_size == 16'd0 && out_piece_address == 16'd0)
  // No new item while a non-final piece waits
  `CFFA_ASSERT_IMP(a_busy_mid, clk, rst_n, out_valid && !out_last_piece, !in_ready)
  // An accepted allocation blocks input next cycle
  `CFFA_ASSERT_NXT(a_alloc_busy, clk, rst_n, in_valid && in_ready && in_req_type, !in_ready)
  // Stalled result holds
  `CFFA_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_piece_size))
endmodule

bind chunked_first_fit_allocator cffa_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_req_type(in_req_type), .out_valid(out_valid), .out_ready(out_ready),
  .out_placed(out_placed), .out_piece_size(out_piece_size),
  .out_piece_address(out_piece_address), .out_last_piece(out_last_piece)
);

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                        req_type;
    logic [cffa_pkg::IndexW-1:0] chunk_index;
    logic [cffa_pkg::SizeW-1:0]  chunk_size;
    logic [cffa_pkg::SizeW-1:0]  chunk_start;
    logic [cffa_pkg::SizeW-1:0]  request_size;
  } alloc_req_t;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 200;
  localparam int HoldCycles    = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        in_req_type = 1'b0;
  logic [cffa_pkg::IndexW-1:0] in_chunk_index = '0;
  logic [cffa_pkg::SizeW-1:0]  in_chunk_size = '0;
  logic [cffa_pkg::SizeW-1:0]  in_chunk_start = '0;
  logic [cffa_pkg::SizeW-1:0]  in_request_size = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        out_placed;
  logic [cffa_pkg::SizeW-1:0]  out_piece_size;
  logic [cffa_pkg::SizeW-1:0]  out_piece_address;
  logic                        out_last_piece;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [cffa_pkg::CountW-1:0] cfg_chunk_count = '0;

  chunked_first_fit_allocator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_chunk_index   (in_chunk_index),
    .in_chunk_size    (in_chunk_size),
    .in_chunk_start   (in_chunk_start),
    .in_request_size  (in_request_size),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_placed       (out_placed),
    .out_piece_size   (out_piece_size),
    .out_piece_address(out_piece_address),
    .out_last_piece   (out_last_piece),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_chunk_count  (cfg_chunk_count)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block state
  logic [cffa_pkg::CountW-1:0] shadow_count = 4'd1;
  logic [cffa_pkg::SizeW-1:0]  shadow_size  [cffa_pkg::NumChunksDef];
  logic [cffa_pkg::SizeW-1:0]  shadow_start [cffa_pkg::NumChunksDef];

  alloc_req_t          pend_reqs[$];
  cffa_pkg::result_t   exp_pieces[$];
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_seq = 0;
  int         errors = 0;

  // Report chunk c before its cut, then take what is still needed from it
  task automatic take_piece(input int c, inout int unsigned need, input logic last);
    cffa_pkg::result_t r;
    int unsigned amt;
    r.placed = 1'b1;
    r.piece_size = shadow_size[c];
    r.piece_address = shadow_start[c];
    r.last_piece = last;
    exp_pieces.insert(exp_pieces.size(), r);
    amt = (need < shadow_size[c]) ? need : shadow_size[c];
    shadow_size[c] = shadow_size[c] - cffa_pkg::SizeW'(amt);
    shadow_start[c] = shadow_start[c] + cffa_pkg::SizeW'(amt);
    need = need - amt;
  endtask

  // Expected pieces of one accepted request
  task automatic place_request(input alloc_req_t it);
    int n;
    int unsigned need;
    int unsigned acc;
    int fin;
    cffa_pkg::result_t fail_r;
    n = (shadow_count > cffa_pkg::NumChunksDef) ? cffa_pkg::NumChunksDef
                                                : int'(shadow_count);
    need = it.request_size;
    if (it.req_type == cffa_pkg::ReqLoad) begin
      shadow_size[it.chunk_index] = it.chunk_size;
      shadow_start[it.chunk_index] = it.chunk_start;
      return;
    end
    // lowest single chunk
    for (int j = 0; j < n; j++) begin
      if (shadow_size[j] >= need) begin
        take_piece(j, need, 1'b1);
        return;
      end
    end
    // first pair of distinct chunks
    for (int j = 0; j + 1 < n; j++) begin
      for (int k = 1; k < n; k++) begin
        if (k != j && int'(shadow_size[j]) + int'(shadow_size[k]) >= need) begin
          take_piece(j, need, 1'b0);
          take_piece(k, need, 1'b1);
          return;
        end
      end
    end
    // run from chunk 0
    if (n > 2) begin
      acc = 0;
      fin = n;
      for (int j = 0; j < n; j++) begin
        acc += shadow_size[j];
        if (acc >= need) begin
          fin = j;
          break;
        end
      end
      if (fin < n) begin
        for (int j = 0; j <= fin; j++) take_piece(j, need, j == fin);
        return;
      end
    end
    fail_r = '{placed: 1'b0, piece_size: '0, piece_address: '0, last_piece: 1'b1};
    exp_pieces.insert(exp_pieces.size(), fail_r);
  endtask

  // Driver: one input transfer at most per edge
  always @(posedge clk) begin
    alloc_req_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        it = '{in_req_type, in_chunk_index, in_chunk_size, in_chunk_start,
               in_request_size};
        place_request(it);
      end
      if (!in_valid || in_ready) begin
        if (pend_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pend_reqs.pop_front();
          in_valid <= 1'b1;
          in_req_type <= it.req_type;
          in_chunk_index <= it.chunk_index;
          in_chunk_size <= it.chunk_size;
          in_chunk_start <= it.chunk_start;
          in_request_size <= it.request_size;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  int hold_cnt = 0;
  int hold_seen = 0;
  always @(posedge clk) begin
    cffa_pkg::result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (exp_pieces.size() == 0) begin
          $display("%0t: unexpected result placed=%0b size=%h addr=%h last=%0b", $time,
                   out_placed, out_piece_size, out_piece_address, out_last_piece);
          errors++;
        end else begin
          want = exp_pieces.pop_front();
          if (out_placed !== want.placed || out_piece_size !== want.piece_size ||
              out_piece_address !== want.piece_address ||
              out_last_piece !== want.last_piece) begin
            $display("%0t: mismatch expected placed=%0b size=%h addr=%h last=%0b", $time,
                     want.placed, want.piece_size, want.piece_address, want.last_piece);
            $display("%0t:          actual   placed=%0b size=%h addr=%h last=%0b", $time,
                     out_placed, out_piece_size, out_piece_address, out_last_piece);
            errors++;
          end
        end
      end
    end
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_cnt = HoldCycles;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any transfer
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WatchdogLimit) begin
      $display("%0t: timeout", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic alloc_req_t mk_load(int idx, int sz, int st);
    alloc_req_t it;
    it.req_type = cffa_pkg::ReqLoad;
    it.chunk_index = cffa_pkg::IndexW'(idx);
    it.chunk_size = cffa_pkg::SizeW'(sz);
    it.chunk_start = cffa_pkg::SizeW'(st);
    it.request_size = cffa_pkg::SizeW'($urandom);
    return it;
  endfunction

  function automatic alloc_req_t mk_alloc(int sz);
    alloc_req_t it;
    it.req_type = cffa_pkg::ReqAlloc;
    it.chunk_index = cffa_pkg::IndexW'($urandom);
    it.chunk_size = cffa_pkg::SizeW'($urandom);
    it.chunk_start = cffa_pkg::SizeW'($urandom);
    it.request_size = cffa_pkg::SizeW'(sz);
    return it;
  endfunction

  // Mostly allocations of 0 to 1200, with reloads mixed in
  function automatic alloc_req_t rand_req();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30)
      return mk_load($urandom_range(0, 7),
                     ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 300),
                     $urandom);
    else if (pick < 38)
      return mk_alloc($urandom);
    else if (pick < 43)
      return mk_alloc(0);
    return mk_alloc($urandom_range(0, 1200));
  endfunction

  task automatic add_req(input alloc_req_t it);
    pend_reqs.insert(pend_reqs.size(), it);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pend_reqs.size() != 0 || in_valid || exp_pieces.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_count(input logic [cffa_pkg::CountW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_chunk_count <= v;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    shadow_count = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic rand_phase(input int cnt, input int sidle, input int rstall,
                            input logic [cffa_pkg::CountW-1:0] cc);
    write_count(cc);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    repeat (cnt) add_req(rand_req());
    wait_idle();
  endtask

  // Stimulus
  initial begin
    for (int i = 0; i < cffa_pkg::NumChunksDef; i++) begin
      shadow_size[i] = '0;
      shadow_start[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset count of one: load every entry first so no read sees an unloaded one
    for (int i = 0; i < cffa_pkg::NumChunksDef; i++) add_req(mk_load(i, 10, 16'h0100 * i));
    add_req(mk_alloc(5));
    add_req(mk_alloc(20));
    wait_idle();

    // full table: single fit, pair with address wrap, run with an empty chunk, failure
    write_count(4'd8);
    add_req(mk_load(0, 10, 16'h0000));
    add_req(mk_load(1, 20, 16'h1000));
    add_req(mk_load(2, 30, 16'h2000));
    add_req(mk_load(3, 40, 16'hFFF8));
    add_req(mk_load(4, 0, 16'hFFFF));
    add_req(mk_load(5, 5, 16'h5000));
    add_req(mk_load(6, 5, 16'h6000));
    add_req(mk_load(7, 5, 16'h7000));
    add_req(mk_alloc(0));
    add_req(mk_alloc(45));
    add_req(mk_alloc(60));
    add_req(mk_alloc(65535));
    add_req(mk_load(0, 65535, 16'hFFFF));
    add_req(mk_alloc(65535));
    wait_idle();

    // no chunks in use: every request fails
    write_count(4'd0);
    add_req(mk_alloc(0));
    add_req(mk_alloc(65535));
    wait_idle();

    rand_phase(20, 0, 0, 4'd8);
    rand_phase(20, 82, 0, 4'd3);
    rand_phase(20, 0, 82, 4'd2);
    rand_phase(20, 30, 30, 4'd15);
    rand_phase(8, 0, 0, 4'd1);
    rand_phase(8, 30, 30, 4'd0);

    // long receiver hold while the sender keeps offering requests
    write_count(4'd8);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_seq = hold_seq + 1;
    repeat (20) add_req(rand_req());
    wait_idle();

    rand_phase(10, 30, 30, 4'($urandom_range(0, 15)));

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
